// ===== rtl/abff_pkg.sv =====
// ----------------------------------------------------------------------------
// abff_pkg
// Shared types, constants and encoders for the allocation bitmap block.
// ----------------------------------------------------------------------------
package abff_pkg;

   localparam int MAX_BITS  = 1024;
   localparam int WORD_BITS = 32;
   localparam int ROWS      = MAX_BITS / WORD_BITS;
   localparam int ROW_W     = $clog2(ROWS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int POS_W     = 10;
   localparam int LEN_W     = 11;
   localparam int OP_W      = 3;
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_BITS);
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

   localparam logic [OP_W-1:0] OP_SET   = 3'd0;
   localparam logic [OP_W-1:0] OP_RESET = 3'd1;
   localparam logic [OP_W-1:0] OP_FLIP  = 3'd2;
   localparam logic [OP_W-1:0] OP_GET   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

   typedef enum logic [2:0] {
      K_NOP,
      K_SET,
      K_RESET,
      K_FLIP,
      K_GET,
      K_CLEAR
   } kind_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
   } req_type;

   typedef struct packed {
      logic             bit_value;
      logic             free_found;
      logic [POS_W-1:0] free_index;
   } rsp_type;

   typedef struct packed {
      kind_type         kind;
      logic [ROW_W-1:0] row;
      logic [BIT_W-1:0] bit_sel;
   } qword_type;

   typedef struct packed {
      logic      valid;
      qword_type word;
   } qlink_type;

   // {found, index} of the lowest zero bit
   function automatic logic [BIT_W:0] first_zero_word(input logic [WORD_BITS-1:0] v);
      logic             found;
      logic [BIT_W-1:0] idx;
      found = 1'b0;
      idx   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!v[i]) begin
            found = 1'b1;
            idx   = BIT_W'(i);
         end
      end
      return {found, idx};
   endfunction

   function automatic logic [ROW_W:0] first_zero_row(input logic [ROWS-1:0] v);
      logic             found;
      logic [ROW_W-1:0] idx;
      found = 1'b0;
      idx   = '0;
      for (int i = ROWS - 1; i >= 0; i--) begin
         if (!v[i]) begin
            found = 1'b1;
            idx   = ROW_W'(i);
         end
      end
      return {found, idx};
   endfunction

endpackage

// ===== rtl/abff_front.sv =====
// ----------------------------------------------------------------------------
// abff_front
// Length register, request classification and a two-word queue to the engine.
// ----------------------------------------------------------------------------
module abff_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  abff_pkg::req_type            req_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [abff_pkg::LEN_W-1:0]   csr_data,
   output logic [abff_pkg::LEN_W-1:0]   len,
   output abff_pkg::qlink_type          q_out,
   input  logic                         q_pop
);
   import abff_pkg::*;

   logic [LEN_W-1:0]  len_ff;
   qword_type         q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              push, in_range;
   qword_type         word_in;

   assign csr_ready = 1'b1;
   assign len       = len_ff;
   assign req_stall = (cnt_ff == QCNT_W'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign in_range  = ({1'b0, req_data.pos} < len_ff);

   always_comb begin
      word_in.row     = req_data.pos[BIT_W +: ROW_W];
      word_in.bit_sel = req_data.pos[BIT_W-1:0];
      case (req_data.op)
         OP_CLEAR: word_in.kind = K_CLEAR;
         OP_SET:   word_in.kind = in_range ? K_SET   : K_NOP;
         OP_RESET: word_in.kind = in_range ? K_RESET : K_NOP;
         OP_FLIP:  word_in.kind = in_range ? K_FLIP  : K_NOP;
         OP_GET:   word_in.kind = in_range ? K_GET   : K_NOP;
         default:  word_in.kind = K_NOP;
      endcase
   end

   assign q_out.valid = (cnt_ff != '0);
   assign q_out.word  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= LEN_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            len_ff <= (csr_data > LEN_MAX) ? LEN_MAX : csr_data;
         end
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !q_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (!push && q_pop) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule

// ===== rtl/abff_engine.sv =====
// ----------------------------------------------------------------------------
// abff_engine
// Bitmap store, read-modify-write and two-level first-zero search.
// ----------------------------------------------------------------------------
module abff_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [abff_pkg::LEN_W-1:0]   len,
   input  abff_pkg::qlink_type          q_in,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output abff_pkg::rsp_type            rsp_data
);
   import abff_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOD,
      S_SEARCH,
      S_FIND
   } state_type;

   state_type            state_ff;
   qword_type            cur_ff;
   logic [ROWS-1:0]      row_valid_ff, full_ff;
   logic [WORD_BITS-1:0] mem [ROWS];
   logic [WORD_BITS-1:0] rd_ff;
   logic                 get_bit_ff, srch_any_ff;
   logic [ROW_W-1:0]     srch_row_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic                 mem_we, mem_re, out_free;
   logic [ROW_W-1:0]     mem_ra;
   logic [WORD_BITS-1:0] old_word, new_word, find_word, in_mask;
   logic [ROW_W:0]       row_pick;
   logic [BIT_W:0]       bit_pick;
   logic [LEN_W-BIT_W-1:0] srch_row_ext;

   assign q_pop     = (state_ff == S_IDLE) && q_in.valid;
   assign mem_re    = q_pop || (state_ff == S_SEARCH);
   assign mem_ra    = (state_ff == S_IDLE) ? q_in.word.row : row_pick[ROW_W-1:0];
   assign mem_we    = (state_ff == S_MOD);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign old_word = row_valid_ff[cur_ff.row] ? rd_ff : '0;

   always_comb begin
      new_word = old_word;
      case (cur_ff.kind)
         K_SET:   new_word[cur_ff.bit_sel] = 1'b1;
         K_RESET: new_word[cur_ff.bit_sel] = 1'b0;
         K_FLIP:  new_word[cur_ff.bit_sel] = !old_word[cur_ff.bit_sel];
         default: new_word = old_word;
      endcase
   end

   assign row_pick     = first_zero_row(full_ff);
   assign srch_row_ext = (LEN_W-BIT_W)'(srch_row_ff);

   // positions at or above the length read as taken
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         if (srch_row_ext < len[LEN_W-1:BIT_W]) begin
            in_mask[b] = 1'b1;
         end else if (srch_row_ext == len[LEN_W-1:BIT_W]) begin
            in_mask[b] = (BIT_W'(b) < len[BIT_W-1:0]);
         end else begin
            in_mask[b] = 1'b0;
         end
      end
   end

   assign find_word = (row_valid_ff[srch_row_ff] ? rd_ff : '0) | ~in_mask;
   assign bit_pick  = first_zero_word(find_word);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cur_ff.row] <= new_word;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_in.valid) begin
                  cur_ff     <= q_in.word;
                  get_bit_ff <= 1'b0;
                  case (q_in.word.kind)
                     K_CLEAR: begin
                        row_valid_ff <= '0;
                        full_ff      <= '0;
                        state_ff     <= S_SEARCH;
                     end
                     K_SET, K_RESET, K_FLIP, K_GET: state_ff <= S_MOD;
                     default: state_ff <= S_SEARCH;
                  endcase
               end
            end
            S_MOD: begin
               row_valid_ff[cur_ff.row] <= 1'b1;
               full_ff[cur_ff.row]      <= &new_word;
               if (cur_ff.kind == K_GET) begin
                  get_bit_ff <= old_word[cur_ff.bit_sel];
               end
               state_ff <= S_SEARCH;
            end
            S_SEARCH: begin
               srch_any_ff <= row_pick[ROW_W];
               srch_row_ff <= row_pick[ROW_W-1:0];
               state_ff    <= S_FIND;
            end
            S_FIND: begin
               if (out_free) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_data_ff.bit_value  <= get_bit_ff;
                  rsp_data_ff.free_found <= srch_any_ff && bit_pick[BIT_W];
                  rsp_data_ff.free_index <= (srch_any_ff && bit_pick[BIT_W]) ?
                                            POS_W'({srch_row_ff, bit_pick[BIT_W-1:0]}) : '0;
                  state_ff               <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/allocation_bitmap_first_free_core.sv =====
// ----------------------------------------------------------------------------
// allocation_bitmap_first_free_core
// Allocation bitmap with set, reset, flip, get and clear, reporting the
// lowest free position after every operation.
//
// req_*: one word per operation (op, pos); req_stall is high while the
//        two-word queue in front of the engine is full.
// rsp_*: one word per request (bit_value, free_found, free_index), held in
//        an output register; rsp_stall holds it and, once the engine has
//        its next result ready, the engine waits with it.
// csr_*: write of active_len, taken every cycle; values above 1024 are
//        saturated. Write only while no request is outstanding.
// Flow: set/reset/flip/get in range read the row, write it back, pick
//       the first non-full row and scan that row; clear and ignored
//       requests go straight to the search. The engine pops no new
//       request until its result has gone to the output register.
// Reset: synchronous; all marks read as zero immediately through per-row
//        valid flags, active_len returns to 1024, queue and output empty.
// ----------------------------------------------------------------------------
module allocation_bitmap_first_free_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  abff_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output abff_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [abff_pkg::LEN_W-1:0]   csr_data
);
   import abff_pkg::*;

   logic [LEN_W-1:0] len;
   qlink_type        q_link;
   logic             q_pop;

   abff_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .len       (len),
      .q_out     (q_link),
      .q_pop     (q_pop)
   );

   abff_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .len       (len),
      .q_in      (q_link),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/abff_checker.sv =====
// ----------------------------------------------------------------------------
// abff_checker
// Port-level checks on the allocation bitmap block.
// ----------------------------------------------------------------------------
module abff_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input abff_pkg::rsp_type          rsp_data
);
   import abff_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.free_found |-> rsp_data.free_index == '0)
      else $error("free_index non-zero with nothing free");

endmodule

bind allocation_bitmap_first_free_core abff_checker u_abff_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/allocation_bitmap_first_free_core_tb.sv =====
// ----------------------------------------------------------------------------
// allocation_bitmap_first_free_core_tb
// Self-checking bench for the allocation bitmap. Drives set, reset, flip,
// get, clear and spare opcodes over a range of active lengths (zero and
// saturating values included), predicts each response word with its own
// bitmap copy and checks every field against the block's output.
// ----------------------------------------------------------------------------
module allocation_bitmap_first_free_core_tb;
   import abff_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int              N_PHASES    = 8;

   class free_slot_board;
      bit          marks [MAX_BITS];
      int unsigned span;
      rsp_type     expected_rsp [$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned full_seen;

      function new();
         foreach (marks[i]) marks[i] = 1'b0;
         span       = MAX_BITS;
         mismatches = 0;
         checked    = 0;
         full_seen  = 0;
      endfunction

      function void set_length(logic [LEN_W-1:0] v);
         span = (v > MAX_BITS) ? MAX_BITS : int'(v);
      endfunction

      function int lowest_free();
         for (int i = 0; i < span; i++)
            if (!marks[i]) return i;
         return -1;
      endfunction

      function void apply_request(req_type r);
         rsp_type     e;
         int unsigned p;
         int          f;
         e = '0;
         p = r.pos;
         if (r.op == OP_CLEAR) begin
            foreach (marks[i]) marks[i] = 1'b0;
         end else if (p < span) begin
            case (r.op)
               OP_SET:   marks[p] = 1'b1;
               OP_RESET: marks[p] = 1'b0;
               OP_FLIP:  marks[p] = ~marks[p];
               OP_GET:   e.bit_value = marks[p];
               default:  ;
            endcase
         end
         f = lowest_free();
         if (f >= 0) begin
            e.free_found = 1'b1;
            e.free_index = POS_W'(f);
         end
         expected_rsp.push_back(e);
      endfunction

      function void flag(string what, int unsigned want, int unsigned got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            flag("unexpected word", 0, 1);
            return;
         end
         e = expected_rsp.pop_front();
         checked++;
         if (!e.free_found) full_seen++;
         if (got.bit_value !== e.bit_value) flag("bit_value", e.bit_value, got.bit_value);
         if (got.free_found !== e.free_found) flag("free_found", e.free_found, got.free_found);
         if (got.free_index !== e.free_index) flag("free_index", e.free_index, got.free_index);
      endfunction
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_data  = '0;

   free_slot_board board = new();

   int unsigned sent        = 0;
   int unsigned hold_left   = 0;
   bit          rx_quiet    = 1'b0;
   bit          tx_quiet    = 1'b0;
   int unsigned lengths_run = 0;

   // length, item count, allocate share and clear share per phase
   int unsigned phase_len   [N_PHASES] = '{2047, 40, 1, 0, 1024, 2, 1025, 33};
   int unsigned phase_items [N_PHASES] = '{700, 250, 80, 60, 150, 200, 100, 260};
   int unsigned phase_alloc [N_PHASES] = '{80, 55, 40, 30, 30, 60, 50, 60};
   int unsigned phase_clear [N_PHASES] = '{0, 2, 3, 3, 2, 2, 2, 2};

   allocation_bitmap_first_free_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned gap_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic sender_rest(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_request(req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.apply_request(r);
      sent++;
   endtask

   task automatic send_op(logic [OP_W-1:0] op, int unsigned pos);
      req_type r;
      r.op  = op;
      r.pos = POS_W'(pos);
      send_request(r);
   endtask

   task automatic wait_drained();
      sender_rest(1);
      while (board.expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_length(logic [LEN_W-1:0] v);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_length(v);
      lengths_run++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type random_request(int unsigned alloc_pct, int unsigned clear_pct);
      req_type     r;
      int unsigned roll;
      int unsigned lim;
      int          f;
      lim  = (board.span == 0) ? 15 : ((board.span + 3 > 1023) ? 1023 : board.span + 3);
      r.pos = ($urandom_range(0, 9) < 7) ? POS_W'($urandom_range(0, lim))
                                         : POS_W'($urandom_range(0, 1023));
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
         r.op = OP_SET;
         f    = board.lowest_free();
         if (f >= 0) r.pos = POS_W'(f);
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < clear_pct)       r.op = OP_CLEAR;
         else if (roll < 5)          r.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         else if (roll < 40)         r.op = OP_GET;
         else if (roll < 60)         r.op = OP_RESET;
         else if (roll < 80)         r.op = OP_FLIP;
         else                        r.op = OP_SET;
      end
      return r;
   endfunction

   // response side: stall schedule at the falling edge
   initial begin
      int unsigned stall_left;
      int unsigned run_left;
      logic        s;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            s = 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            s = 1'b1;
            stall_left--;
         end else if (run_left > 0) begin
            s = 1'b0;
            run_left--;
         end else begin
            s = 1'b0;
            if (rx_quiet)                      run_left = 50;
            else if ($urandom_range(0, 9) < 6) run_left = $urandom_range(0, 12);
            else                               stall_left = gap_len() - 1;
         end
         rsp_stall <= s;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);

   initial begin
      #10ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every opcode, out-of-range, zero and saturated length
      send_op(OP_GET, 0);
      send_op(OP_SET, 0);
      send_op(OP_SET, 1023);
      send_op(OP_GET, 1023);
      send_op(OP_FLIP, 1);
      send_op(OP_FLIP, 1);
      send_op(OP_RESET, 0);
      send_op(OP_GET, 0);
      send_op(OP_SPARE_LO, 0);
      send_op(OP_SPARE_LO + 3'd1, 512);
      send_op(OP_SPARE_HI, 1023);
      send_op(OP_CLEAR, 1023);
      send_op(OP_SET, 1023);
      write_length(LEN_W'(8));
      send_op(OP_SET, 8);
      send_op(OP_GET, 1023);
      send_op(OP_FLIP, 7);
      send_op(OP_GET, 7);
      send_op(OP_CLEAR, 0);
      write_length(LEN_MAX);
      send_op(OP_GET, 1023);
      write_length('0);
      send_op(OP_SET, 0);
      send_op(OP_GET, 0);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         if (ph == 5) phase_len[ph] = $urandom_range(2, 1023);
         write_length(LEN_W'(phase_len[ph]));
         tx_quiet = (ph == 1) || (ph == 6);
         rx_quiet = (ph == 4);
         if (ph == 1) hold_left = 120;
         for (int n = 0; n < phase_items[ph]; n++) begin
            if (ph == 0 && n == phase_items[ph] / 2) wait_drained();
            if (!tx_quiet && $urandom_range(0, 2) == 0) sender_rest(gap_len());
            send_request(random_request(phase_alloc[ph], phase_clear[ph]));
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("Ran %0d operations over %0d length settings; %0d words checked, %0d with no free slot.",
               sent, lengths_run, board.checked, board.full_seen);
      if (board.expected_rsp.size() != 0)
         $display("%0d expected words never arrived", board.expected_rsp.size());
      if (board.mismatches == 0 && board.expected_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/abff_pkg.sv
rtl/abff_front.sv
rtl/abff_engine.sv
rtl/allocation_bitmap_first_free_core.sv
rtl/abff_checker.sv
tb/allocation_bitmap_first_free_core_tb.sv
